// ----- hdl/bfa_pkg.sv -----
// Shared constants, types and helpers for the bitmap frame allocator.
package bfa_pkg;

   localparam int WORD_BITS     = 64;             // frames per bitmap word
   localparam int BIT_IDX_W     = 6;              // bit index inside a word
   localparam int FRAME_IDX_W   = 16;             // frame number
   localparam int FRAME_CNT_W   = 17;             // frame counts, managed frame total
   localparam int FRAME_EXT_W   = 18;             // word * 64 + bit, with headroom
   localparam int ACTION_W      = 2;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 56;

   localparam int DEF_BITMAP_WORDS = 1024;
   localparam int DEF_FRAME_BYTES  = 4096;

   localparam logic [FRAME_CNT_W-1:0] TOTAL_FRAMES_RST = 17'd65536;
   localparam logic [WORD_BITS-1:0]   WORD_FULL        = {WORD_BITS{1'b1}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_INIT  = 2'd0,
      ACT_ALLOC = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_QUERY = 2'd3
   } bfa_action_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MARK   = 6'b000010,
      S_CLEAR  = 6'b000100,
      S_ALLOC  = 6'b001000,
      S_LOOKUP = 6'b010000,
      S_REPLY  = 6'b100000
   } bfa_state_type;

   // lowest clear bit of a word; 0 when the word is full
   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- hdl/bitmap_frame_allocator.sv -----
// Top level of the first-fit bitmap frame allocator.
//
// First-fit page frame allocator over a bitmap of BITMAP_WORDS 64-bit words held in one
// synchronous RAM (one bit per frame, set = used). Each request transaction carries an
// action in req_tuser (0 init, 1 allocate, 2 free, 3 query) and a frame number in
// req_tdata; each produces exactly one response transaction with ok, the granted frame,
// the query answer and the used/free counts after the action. The managed frame count is
// written on the csr port and latched by init; init must come before any other action.
// Init clears words 0..ceil(frames/64)-1 with a one-word-per-cycle pass and marks the
// frames that hold the bitmap itself, ceil(words*8/FRAME_BYTES), as used. One request is
// in work at a time; the response sits in an output register, so a new request is taken
// while the previous response still waits. Free and query do one RAM read, one
// check/write-back and one response load; out-of-range requests and requests before
// init go straight to the response load. Allocate steps over full words starting from
// a hint below which all words are full; init counts the marked frames, then clears
// the words (bad size: straight to the response load). The response load waits while
// the previous response is still held.
module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int BITMAP_WORDS = DEF_BITMAP_WORDS,
   parameter int FRAME_BYTES  = DEF_FRAME_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration: managed frame count
   input  logic                   csr_wr_en,
   input  logic [FRAME_CNT_W-1:0] csr_wr_data,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] frame_index
   input  logic [ACTION_W-1:0]    req_tuser,   // [1:0] action
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [0] ok, [16:1] granted_frame,
                                               // [17] is_allocated, [34:18] used_count,
                                               // [51:35] free_count, [55:52] zero
);

   // RAM address width, and width of a word count that can hold BITMAP_WORDS itself
   localparam int AW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int WCW   = $clog2(BITMAP_WORDS + 1);
   // byte accumulator for counting bitmap frames: stays below words*8 + FRAME_BYTES
   localparam int ACC_W = $clog2(BITMAP_WORDS * 8 + FRAME_BYTES + 1);
   localparam int TFW_W = FRAME_CNT_W + 1 - BIT_IDX_W;   // ceil(frames/64)

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   bfa_state_type              state_ff, state_in;
   logic [FRAME_CNT_W-1:0]     frame_total_ff;
   logic                       valid_ff, valid_in;
   logic [FRAME_CNT_W-1:0]     live_frames_ff, live_frames_in;
   logic [WCW-1:0]             live_words_ff, live_words_in;
   logic [FRAME_CNT_W-1:0]     used_ff, used_in;
   logic [AW-1:0]              hint_ff, hint_in;     // all words below are full

   bfa_action_type             action_ff, action_in;
   logic [FRAME_IDX_W-1:0]     frame_ff, frame_in;
   logic [AW-1:0]              scan_ff, scan_in;     // word whose data is in rdata
   logic [AW-1:0]              sweep_ff, sweep_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [FRAME_CNT_W-1:0]     marks_ff, marks_in;
   logic                       ok_pend_ff, ok_pend_in;
   logic [FRAME_IDX_W-1:0]     grant_pend_ff, grant_pend_in;
   logic                       isalloc_pend_ff, isalloc_pend_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // bitmap RAM
   logic [WORD_BITS-1:0]       bitmap_mem [BITMAP_WORDS];
   logic [WORD_BITS-1:0]       bitmap_rdata_ff;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [WORD_BITS-1:0]       wr_data;

   // ---------------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------------
   logic                       in_xfer;
   logic                       out_free;
   bfa_action_type             req_action;
   logic [FRAME_IDX_W-1:0]     req_frame;
   logic [TFW_W-1:0]           tf_words;
   logic                       init_bad;
   logic                       frame_out_of_range;
   logic [ACC_W-1:0]           mark_target;
   logic [FRAME_EXT_W-1:0]     sweep_base;
   logic [FRAME_EXT_W-1:0]     marks_ext;
   logic [BIT_IDX_W-1:0]       mark_bits;
   logic [WORD_BITS-1:0]       clear_word;
   logic                       word_full;
   logic [BIT_IDX_W-1:0]       zero_bit;
   logic [FRAME_EXT_W-1:0]     cand_frame;
   logic [AW-1:0]              frame_word;
   logic                       frame_bit;
   logic [FRAME_CNT_W-1:0]     free_count;

   assign req_tready = (state_ff == S_IDLE);
   assign in_xfer    = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_action = bfa_action_type'(req_tuser);
   assign req_frame  = req_tdata[FRAME_IDX_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // words needed for the programmed frame count
   assign tf_words = TFW_W'(({1'b0, frame_total_ff} + (FRAME_CNT_W + 1)'(WORD_BITS - 1))
                            >> BIT_IDX_W);
   assign init_bad = (frame_total_ff == '0) || (32'(tf_words) > BITMAP_WORDS);

   assign frame_out_of_range = !valid_ff || (FRAME_CNT_W'(req_frame) >= live_frames_ff);

   // bitmap bytes = words * 8
   assign mark_target = ACC_W'(live_words_ff) << 3;

   // init word: bits of frames below marks_ff set
   assign sweep_base = FRAME_EXT_W'(sweep_ff) << BIT_IDX_W;
   assign marks_ext  = FRAME_EXT_W'(marks_ff);
   assign mark_bits  = BIT_IDX_W'(marks_ext - sweep_base);
   always_comb begin
      priority if (marks_ext >= sweep_base + FRAME_EXT_W'(WORD_BITS)) begin
         clear_word = WORD_FULL;
      end else if (marks_ext > sweep_base) begin
         clear_word = ~(WORD_FULL << mark_bits);
      end else begin
         clear_word = '0;
      end
   end

   // allocate scan
   assign word_full  = &bitmap_rdata_ff;
   assign zero_bit   = first_zero(bitmap_rdata_ff);
   assign cand_frame = (FRAME_EXT_W'(scan_ff) << BIT_IDX_W) | FRAME_EXT_W'(zero_bit);

   // free / query
   assign frame_word = AW'(frame_ff >> BIT_IDX_W);
   assign frame_bit  = bitmap_rdata_ff[frame_ff[BIT_IDX_W-1:0]];

   assign free_count = (live_frames_ff >= used_ff) ? (live_frames_ff - used_ff) : '0;

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      live_frames_in  = live_frames_ff;
      live_words_in   = live_words_ff;
      used_in         = used_ff;
      hint_in         = hint_ff;
      action_in       = action_ff;
      frame_in        = frame_ff;
      scan_in         = scan_ff;
      sweep_in        = sweep_ff;
      acc_in          = acc_ff;
      marks_in        = marks_ff;
      ok_pend_in      = ok_pend_ff;
      grant_pend_in   = grant_pend_ff;
      isalloc_pend_in = isalloc_pend_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;

      rd_en   = 1'b0;
      rd_addr = hint_ff;
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = clear_word;

      unique case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               action_in       = req_action;
               frame_in        = req_frame;
               ok_pend_in      = 1'b0;
               grant_pend_in   = '0;
               isalloc_pend_in = 1'b0;
               unique case (req_action)
                  ACT_INIT: begin
                     valid_in = 1'b0;
                     used_in  = '0;
                     hint_in  = '0;
                     acc_in   = '0;
                     marks_in = '0;
                     if (init_bad) begin
                        live_frames_in = '0;
                        live_words_in  = '0;
                        state_in       = S_REPLY;
                     end else begin
                        live_frames_in = frame_total_ff;
                        live_words_in  = WCW'(tf_words);
                        state_in       = S_MARK;
                     end
                  end
                  ACT_ALLOC: begin
                     if (!valid_ff) begin
                        state_in = S_REPLY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = hint_ff;
                        scan_in  = hint_ff;
                        state_in = S_ALLOC;
                     end
                  end
                  ACT_FREE, ACT_QUERY: begin
                     if (frame_out_of_range) begin
                        state_in = S_REPLY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_frame >> BIT_IDX_W);
                        state_in = S_LOOKUP;
                     end
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end

         // count frames covered by the bitmap: ceil(words*8 / FRAME_BYTES)
         S_MARK: begin
            if (acc_ff < mark_target) begin
               acc_in   = acc_ff + ACC_W'(FRAME_BYTES);
               marks_in = marks_ff + FRAME_CNT_W'(1);
            end else begin
               if (marks_ff > live_frames_ff) begin
                  marks_in = live_frames_ff;
               end
               sweep_in = '0;
               state_in = S_CLEAR;
            end
         end

         // one word per cycle: zero, or the low frames marked as used
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = clear_word;
            if (WCW'(sweep_ff) + WCW'(1) == live_words_ff) begin
               used_in    = marks_ff;
               valid_in   = 1'b1;
               hint_in    = '0;
               ok_pend_in = 1'b1;
               state_in   = S_REPLY;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end

         // rdata holds word scan_ff; next word is read while this one is full
         S_ALLOC: begin
            if (!word_full) begin
               if (cand_frame >= FRAME_EXT_W'(live_frames_ff)) begin
                  state_in = S_REPLY;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = scan_ff;
                  wr_data       = bitmap_rdata_ff | (WORD_BITS'(1) << zero_bit);
                  used_in       = used_ff + FRAME_CNT_W'(1);
                  hint_in       = scan_ff;
                  ok_pend_in    = 1'b1;
                  grant_pend_in = cand_frame[FRAME_IDX_W-1:0];
                  state_in      = S_REPLY;
               end
            end else if (WCW'(scan_ff) + WCW'(1) < live_words_ff) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff + AW'(1);
               scan_in = scan_ff + AW'(1);
            end else begin
               state_in = S_REPLY;
            end
         end

         S_LOOKUP: begin
            if (action_ff == ACT_FREE) begin
               if (frame_bit) begin
                  wr_en      = 1'b1;
                  wr_addr    = frame_word;
                  wr_data    = bitmap_rdata_ff & ~(WORD_BITS'(1) << frame_ff[BIT_IDX_W-1:0]);
                  used_in    = used_ff - FRAME_CNT_W'(1);
                  ok_pend_in = 1'b1;
                  if (frame_word < hint_ff) begin
                     hint_in = frame_word;
                  end
               end
            end else begin
               ok_pend_in      = 1'b1;
               isalloc_pend_in = frame_bit;
            end
            state_in = S_REPLY;
         end

         // load the output register once it is free
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, free_count, used_ff, isalloc_pend_ff,
                               grant_pend_ff, ok_pend_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         frame_total_ff  <= TOTAL_FRAMES_RST;
         valid_ff        <= 1'b0;
         live_frames_ff  <= '0;
         live_words_ff   <= '0;
         used_ff         <= '0;
         hint_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         live_frames_ff  <= live_frames_in;
         live_words_ff   <= live_words_in;
         used_ff         <= used_in;
         hint_ff         <= hint_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            frame_total_ff <= csr_wr_data;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Working and payload registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      frame_ff        <= frame_in;
      scan_ff         <= scan_in;
      sweep_ff        <= sweep_in;
      acc_ff          <= acc_in;
      marks_ff        <= marks_in;
      ok_pend_ff      <= ok_pend_in;
      grant_pend_ff   <= grant_pend_in;
      isalloc_pend_ff <= isalloc_pend_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // ---------------------------------------------------------------------------
   // Bitmap RAM: one write and one registered read per cycle
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         bitmap_rdata_ff <= bitmap_mem[rd_addr];
      end
   end

endmodule
